FILE: sv/assert_macros.svh
// Assertion macros shared by the thruster mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising clock edge, off while reset is low.
`define TMHH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication check on the rising clock edge, off while reset is low.
`define TMHH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/tmhh_pkg.sv
// Shared types, widths and constants of the thruster mixer with heading hold.
`timescale 1ns / 1ps

package tmhh_pkg;

  localparam int unsigned ADC_BITS_DEF = 10;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFF_W     = 9;
  localparam int unsigned DEB_W     = 16;
  localparam int unsigned PULSE_W   = 12;
  localparam int unsigned HEAD_W    = 13;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned YAW_W     = 9;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int NEUTRAL_PULSE = 1500;
  localparam int HALF_TURN_Q4  = 2880;
  localparam int FULL_TURN_Q4  = 5760;
  // Q4 error times Q4 gain leaves eight fraction bits.
  localparam int unsigned GAIN_SHIFT = 8;

  localparam logic [BYTE_W-1:0]  DEADZONE_RST   = 8'd60;
  localparam logic [OFF_W-1:0]   AXIS_OFS_RST   = 9'd100;
  localparam logic [BYTE_W-1:0]  YAW_LIM_RST    = 8'd30;
  localparam logic [BYTE_W-1:0]  YAW_GAIN_RST   = 8'd24;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 16'd50;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 12'd1400;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 12'd1600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE    = 3'd0,
    CFG_AXIS_OFFSET = 3'd1,
    CFG_YAW_LIMIT   = 3'd2,
    CFG_YAW_GAIN    = 3'd3,
    CFG_DEBOUNCE    = 3'd4,
    CFG_IMU_PRESENT = 3'd5,
    CFG_MIN_PULSE   = 3'd6,
    CFG_MAX_PULSE   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  deadzone;
    logic [OFF_W-1:0]   max_axis_offset;
    logic [BYTE_W-1:0]  max_yaw_correction;
    logic [BYTE_W-1:0]  yaw_gain_q4;
    logic [DEB_W-1:0]   debounce_ms;
    logic               imu_present;
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] max_pulse;
  } cfg_t;

  typedef enum logic [1:0] {
    AX_THROTTLE = 2'd0,
    AX_STEERING = 2'd1,
    AX_VERTICAL = 2'd2
  } axis_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  eval;
    logic  prep;
    logic  div_step;
    logic  store;
    logic  err;
    logic  ymul;
    logic  corr;
    logic  mix;
    axis_e axis;
  } dp_cmd_t;

endpackage

FILE: sv/tmhh_in_if.sv
// Input channel of the thruster mixer: one control tick per transfer.
`timescale 1ns / 1ps

interface tmhh_in_if #(
  parameter int unsigned ADC_BITS = tmhh_pkg::ADC_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [ADC_BITS-1:0]               throttle_raw;
  logic [ADC_BITS-1:0]               steering_raw;
  logic [ADC_BITS-1:0]               vertical_raw;
  logic                              toggle_level;
  logic                              stop_pressed;
  logic [tmhh_pkg::HEAD_W-1:0]       heading;
  logic [tmhh_pkg::TIME_W-1:0]       now_ms;

  modport source (
    output valid, throttle_raw, steering_raw, vertical_raw, toggle_level,
           stop_pressed, heading, now_ms,
    input  ready
  );

  modport sink (
    input  valid, throttle_raw, steering_raw, vertical_raw, toggle_level,
           stop_pressed, heading, now_ms,
    output ready
  );
endinterface

FILE: sv/tmhh_out_if.sv
// Output channel of the thruster mixer: pulse widths and heading hold status.
`timescale 1ns / 1ps

interface tmhh_out_if;
  logic                               valid;
  logic                               ready;
  logic [tmhh_pkg::PULSE_W-1:0]       left_pulse;
  logic [tmhh_pkg::PULSE_W-1:0]       right_pulse;
  logic [tmhh_pkg::PULSE_W-1:0]       vertical_pulse;
  logic                               hold_active;
  logic signed [tmhh_pkg::YAW_W-1:0]  yaw_correction;
  logic signed [tmhh_pkg::HEAD_W-1:0] heading_error;

  modport source (
    output valid, left_pulse, right_pulse, vertical_pulse, hold_active,
           yaw_correction, heading_error,
    input  ready
  );

  modport sink (
    input  valid, left_pulse, right_pulse, vertical_pulse, hold_active,
           yaw_correction, heading_error,
    output ready
  );
endinterface

FILE: sv/thruster_mixer_heading_hold_top.sv
// Top level of the thruster mixer with heading hold.
//
//   Port    Direction  Handshake                Carries
//   in_i    sink       valid/ready transfer     three ADC axes, buttons, heading, ms time
//   out_o   source     valid/ready transfer     three pulse widths, hold, yaw, heading error
//   cfg_*   in         write enable, no wait    register index and data, eight registers
//
// One tick occupies the block from the input transfer until the block is ready again; no
// new tick is taken before then. The tick walks debounce, a prep, divide and store step
// for each axis, then the yaw error, multiply and correction steps and the mix. The shared
// restoring divider yields one quotient bit per cycle and runs once for each of the three axes.
// Reset is asynchronous and active low: registers return to their defaults, button and
// hold state to released and off. No clearing pass follows.
// A stalled result waits in the output register; the next tick is taken meanwhile and
// holds in its mix step until the waiting result has been transferred.
`timescale 1ns / 1ps

module thruster_mixer_heading_hold_top #(
  parameter int unsigned ADC_BITS = tmhh_pkg::ADC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tmhh_in_if.sink                        in_i,
  tmhh_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [tmhh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tmhh_pkg::CFG_W-1:0]     cfg_wdata_i
);

  tmhh_pkg::cfg_t    cfg;
  tmhh_pkg::dp_cmd_t cmd;

  // Register file: the user must write it only while no tick is in flight; the block does not enforce it.
  tmhh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Controller: walks debounce, three axis divisions, yaw loop, mix.
  tmhh_ctrl #(
    .ADC_BITS (ADC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: holds the tick, the persistent hold state and the output register.
  tmhh_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .throttle_raw_i   (in_i.throttle_raw),
    .steering_raw_i   (in_i.steering_raw),
    .vertical_raw_i   (in_i.vertical_raw),
    .toggle_level_i   (in_i.toggle_level),
    .stop_pressed_i   (in_i.stop_pressed),
    .heading_i        (in_i.heading),
    .now_ms_i         (in_i.now_ms),
    .left_pulse_o     (out_o.left_pulse),
    .right_pulse_o    (out_o.right_pulse),
    .vertical_pulse_o (out_o.vertical_pulse),
    .hold_active_o    (out_o.hold_active),
    .yaw_correction_o (out_o.yaw_correction),
    .heading_error_o  (out_o.heading_error)
  );

endmodule

FILE: sv/tmhh_cfg.sv
// Configuration register file of the thruster mixer.
`timescale 1ns / 1ps

module tmhh_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tmhh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tmhh_pkg::CFG_W-1:0]     cfg_wdata_i,
  output tmhh_pkg::cfg_t                 cfg_o
);

  tmhh_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tmhh_pkg::cfg_idx_e'(cfg_idx_i))
        tmhh_pkg::CFG_DEADZONE:    cfg_d.deadzone           = cfg_wdata_i[7:0];
        tmhh_pkg::CFG_AXIS_OFFSET: cfg_d.max_axis_offset    = cfg_wdata_i[8:0];
        tmhh_pkg::CFG_YAW_LIMIT:   cfg_d.max_yaw_correction = cfg_wdata_i[7:0];
        tmhh_pkg::CFG_YAW_GAIN:    cfg_d.yaw_gain_q4        = cfg_wdata_i[7:0];
        tmhh_pkg::CFG_DEBOUNCE:    cfg_d.debounce_ms        = cfg_wdata_i[15:0];
        tmhh_pkg::CFG_IMU_PRESENT: cfg_d.imu_present        = cfg_wdata_i[0];
        tmhh_pkg::CFG_MIN_PULSE:   cfg_d.min_pulse          = cfg_wdata_i[11:0];
        tmhh_pkg::CFG_MAX_PULSE:   cfg_d.max_pulse          = cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone           <= tmhh_pkg::DEADZONE_RST;
      cfg_q.max_axis_offset    <= tmhh_pkg::AXIS_OFS_RST;
      cfg_q.max_yaw_correction <= tmhh_pkg::YAW_LIM_RST;
      cfg_q.yaw_gain_q4        <= tmhh_pkg::YAW_GAIN_RST;
      cfg_q.debounce_ms        <= tmhh_pkg::DEBOUNCE_RST;
      cfg_q.imu_present        <= 1'b0;
      cfg_q.min_pulse          <= tmhh_pkg::MIN_PULSE_RST;
      cfg_q.max_pulse          <= tmhh_pkg::MAX_PULSE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/tmhh_ctrl.sv
// Sequencing controller of the thruster mixer: one tick at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmhh_ctrl #(
  parameter int unsigned ADC_BITS = tmhh_pkg::ADC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tmhh_pkg::dp_cmd_t cmd_o
);

  // Divider runs one quotient bit per step over the full numerator width.
  localparam int unsigned NUM_W = ADC_BITS - 1 + tmhh_pkg::OFF_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EVAL  = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_STORE = 9'b000010000,
    S_ERR   = 9'b000100000,
    S_YMUL  = 9'b001000000,
    S_CORR  = 9'b010000000,
    S_MIX   = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  tmhh_pkg::axis_e     axis_q, axis_d;
  logic [CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        axis_d     = tmhh_pkg::AX_THROTTLE;
        state_d    = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        div_cnt_d  = CNT_W'(NUM_W - 1);
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        unique case (axis_q)
          tmhh_pkg::AX_THROTTLE: begin
            axis_d  = tmhh_pkg::AX_STEERING;
            state_d = S_PREP;
          end
          tmhh_pkg::AX_STEERING: begin
            axis_d  = tmhh_pkg::AX_VERTICAL;
            state_d = S_PREP;
          end
          default: begin
            axis_d  = tmhh_pkg::AX_THROTTLE;
            state_d = S_ERR;
          end
        endcase
      end
      S_ERR: begin
        cmd_o.err = 1'b1;
        state_d   = S_YMUL;
      end
      S_YMUL: begin
        cmd_o.ymul = 1'b1;
        state_d    = S_CORR;
      end
      S_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = S_MIX;
      end
      S_MIX: begin
        // Hold the finished tick until the output register frees up.
        if (out_free) begin
          cmd_o.mix   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= tmhh_pkg::AX_THROTTLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TMHH_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "input taken while a tick is in flight")
  `TMHH_ASSERT_IMP(a_result_from_mix, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_MIX), "result raised outside the mix step")
  `TMHH_ASSERT_IMP(a_store_after_div, clk_i, rst_ni, state_q == S_STORE, $past(state_q == S_DIV) && $past(div_cnt_q == '0), "quotient stored before the divider finished")

endmodule

FILE: sv/tmhh_dp.sv
// Datapath of the thruster mixer: debounce, axis mapping, yaw loop and mixing.
`timescale 1ns / 1ps

module tmhh_dp #(
  parameter int unsigned ADC_BITS = tmhh_pkg::ADC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tmhh_pkg::dp_cmd_t                   cmd_i,
  input  tmhh_pkg::cfg_t                      cfg_i,
  input  logic [ADC_BITS-1:0]                 throttle_raw_i,
  input  logic [ADC_BITS-1:0]                 steering_raw_i,
  input  logic [ADC_BITS-1:0]                 vertical_raw_i,
  input  logic                                toggle_level_i,
  input  logic                                stop_pressed_i,
  input  logic [tmhh_pkg::HEAD_W-1:0]         heading_i,
  input  logic [tmhh_pkg::TIME_W-1:0]         now_ms_i,
  output logic [tmhh_pkg::PULSE_W-1:0]        left_pulse_o,
  output logic [tmhh_pkg::PULSE_W-1:0]        right_pulse_o,
  output logic [tmhh_pkg::PULSE_W-1:0]        vertical_pulse_o,
  output logic                                hold_active_o,
  output logic signed [tmhh_pkg::YAW_W-1:0]   yaw_correction_o,
  output logic signed [tmhh_pkg::HEAD_W-1:0]  heading_error_o
);

  localparam int unsigned OFF_W   = tmhh_pkg::OFF_W;
  localparam int unsigned BYTE_W  = tmhh_pkg::BYTE_W;
  localparam int unsigned HEAD_W  = tmhh_pkg::HEAD_W;
  localparam int unsigned TIME_W  = tmhh_pkg::TIME_W;
  localparam int unsigned PULSE_W = tmhh_pkg::PULSE_W;
  localparam int unsigned YAW_W   = tmhh_pkg::YAW_W;
  localparam int unsigned CENTER  = 1 << (ADC_BITS - 1);
  localparam int unsigned CW      = ADC_BITS + 2;
  localparam int unsigned DEN_W   = ADC_BITS - 1;
  localparam int unsigned NUM_W   = DEN_W + OFF_W;
  localparam int unsigned OFS_W   = OFF_W + 1;
  localparam int unsigned PROD_W  = HEAD_W + BYTE_W + 1;
  localparam int unsigned MAG_W   = PROD_W - tmhh_pkg::GAIN_SHIFT;
  localparam int unsigned SUM_W   = PULSE_W + 2;
  localparam int unsigned ERR_W   = HEAD_W + 1;

  localparam logic signed [CW-1:0]    CENTER_S  = CW'(CENTER);
  localparam logic signed [ERR_W-1:0] HALF_S    = ERR_W'(tmhh_pkg::HALF_TURN_Q4);
  localparam logic signed [ERR_W-1:0] FULL_S    = ERR_W'(tmhh_pkg::FULL_TURN_Q4);
  localparam logic signed [SUM_W-1:0] NEUTRAL_S = SUM_W'(tmhh_pkg::NEUTRAL_PULSE);

  // Low bound is tested first: when the bounds cross, values below it give the low bound, all others the high bound.
  function automatic logic [PULSE_W-1:0] clamp_pulse(
    input logic signed [SUM_W-1:0] v,
    input logic [PULSE_W-1:0]      lo,
    input logic [PULSE_W-1:0]      hi
  );
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic [PULSE_W-1:0]      r;
    lo_s = signed'(SUM_W'(lo));
    hi_s = signed'(SUM_W'(hi));
    if (v < lo_s) begin
      r = lo;
    end else if (v > hi_s) begin
      r = hi;
    end else begin
      r = v[PULSE_W-1:0];
    end
    return r;
  endfunction

  // Latched tick
  logic [ADC_BITS-1:0]      thr_raw_q, str_raw_q, ver_raw_q;
  logic                     tog_q, stop_q;
  logic [HEAD_W-1:0]        heading_q;
  logic [TIME_W-1:0]        now_q;

  // Persistent button and hold state
  logic                     last_q, stable_q, hold_q;
  logic [TIME_W-1:0]        change_q;
  logic [HEAD_W-1:0]        target_q;

  // Debounce and hold update
  logic                     chg, fire, press, hold_n;
  logic [TIME_W-1:0]        ct, elapsed;
  logic [HEAD_W-1:0]        target_n;

  // Axis mapping
  logic [ADC_BITS-1:0]      raw_sel;
  logic signed [CW-1:0]     c_s, dz_s, mag_s, span_s;
  logic                     in_band, pos, no_span;
  logic [NUM_W-1:0]         num_d;
  logic                     neg_q, zero_q;
  logic [DEN_W-1:0]         den_q, rem_q, rem_d;
  logic [NUM_W-1:0]         quo_q;
  logic [DEN_W:0]           trial;
  logic                     ge;
  logic [OFF_W-1:0]         quot;
  logic signed [OFS_W-1:0]  ofs_val;
  logic signed [OFS_W-1:0]  thr_ofs_q, str_ofs_q, ver_ofs_q;

  // Yaw loop
  logic signed [ERR_W-1:0]  e_raw, e_wrap;
  logic signed [HEAD_W-1:0] err_q, err_d;
  logic signed [PROD_W-1:0] p_q, p_d;
  logic [PROD_W-1:0]        p_abs;
  logic [MAG_W-1:0]         p_mag;
  logic [BYTE_W-1:0]        sat;
  logic signed [YAW_W-1:0]  corr_q, corr_d;

  // Mixing
  logic signed [SUM_W-1:0]  sum_l, sum_r, sum_v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      thr_raw_q <= throttle_raw_i;
      str_raw_q <= steering_raw_i;
      ver_raw_q <= vertical_raw_i;
      tog_q     <= toggle_level_i;
      stop_q    <= stop_pressed_i;
      heading_q <= heading_i;
      now_q     <= now_ms_i;
    end
  end

  always_comb begin
    chg      = tog_q != last_q;
    ct       = chg ? now_q : change_q;
    elapsed  = now_q - ct;
    fire     = (elapsed > TIME_W'(cfg_i.debounce_ms)) && (tog_q != stable_q);
    press    = fire && !tog_q;
    hold_n   = hold_q;
    target_n = target_q;
    if (press) begin
      if (!cfg_i.imu_present) begin
        hold_n = 1'b0;
      end else begin
        hold_n = !hold_q;
        if (!hold_q) begin
          target_n = heading_q;
        end
      end
    end
    // Drop the target whenever hold is off; stop ends hold.
    if (!hold_n || stop_q) begin
      target_n = '0;
    end
    if (stop_q) begin
      hold_n = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      change_q <= '0;
      hold_q   <= 1'b0;
      target_q <= '0;
    end else if (cmd_i.eval) begin
      last_q   <= tog_q;
      stable_q <= fire ? tog_q : stable_q;
      change_q <= ct;
      hold_q   <= hold_n;
      target_q <= target_n;
    end
  end

  always_comb begin
    case (cmd_i.axis)
      tmhh_pkg::AX_STEERING: raw_sel = str_raw_q;
      tmhh_pkg::AX_VERTICAL: raw_sel = ver_raw_q;
      default:               raw_sel = thr_raw_q;
    endcase
    c_s     = signed'(CW'(raw_sel)) - CENTER_S;
    dz_s    = signed'(CW'(cfg_i.deadzone));
    in_band = (c_s >= -dz_s) && (c_s <= dz_s);
    pos     = !c_s[CW-1] && (c_s != '0);
    mag_s   = pos ? (c_s - dz_s - CW'(1)) : (-c_s - dz_s - CW'(1));
    span_s  = pos ? (CENTER_S - dz_s - CW'(2)) : (CENTER_S - dz_s - CW'(1));
    no_span = span_s[CW-1] || (span_s == '0);
    num_d   = NUM_W'(mag_s[DEN_W-1:0]) * NUM_W'(cfg_i.max_axis_offset);
  end

  // Restoring divider, one quotient bit per step.
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      quo_q  <= num_d;
      rem_q  <= '0;
      den_q  <= span_s[DEN_W-1:0];
      neg_q  <= !pos;
      zero_q <= in_band || no_span;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  // Quotient never exceeds the full deflection offset.
  always_comb begin
    quot = quo_q[OFF_W-1:0];
    if (zero_q) begin
      ofs_val = '0;
    end else if (neg_q) begin
      ofs_val = -signed'({1'b0, quot});
    end else begin
      ofs_val = signed'({1'b0, quot});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      case (cmd_i.axis)
        tmhh_pkg::AX_STEERING: str_ofs_q <= ofs_val;
        tmhh_pkg::AX_VERTICAL: ver_ofs_q <= ofs_val;
        default:               thr_ofs_q <= ofs_val;
      endcase
    end
  end

  always_comb begin
    e_raw = signed'({1'b0, target_q}) - signed'({1'b0, heading_q});
    if (e_raw > HALF_S) begin
      e_wrap = e_raw - FULL_S;
    end else if (e_raw < -HALF_S) begin
      e_wrap = e_raw + FULL_S;
    end else begin
      e_wrap = e_raw;
    end
    err_d = (hold_q && cfg_i.imu_present) ? e_wrap[HEAD_W-1:0] : '0;
    p_d   = signed'(PROD_W'(err_q)) * signed'(PROD_W'({1'b0, cfg_i.yaw_gain_q4}));
    // Truncate toward zero through the magnitude, then saturate.
    p_abs = p_q[PROD_W-1] ? -p_q : p_q;
    p_mag = p_abs[PROD_W-1:tmhh_pkg::GAIN_SHIFT];
    sat   = (p_mag > MAG_W'(cfg_i.max_yaw_correction)) ? cfg_i.max_yaw_correction
                                                        : p_mag[BYTE_W-1:0];
    corr_d = p_q[PROD_W-1] ? -signed'(YAW_W'(sat)) : signed'(YAW_W'(sat));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err) begin
      err_q <= err_d;
    end
    if (cmd_i.ymul) begin
      p_q <= p_d;
    end
    if (cmd_i.corr) begin
      corr_q <= corr_d;
    end
  end

  always_comb begin
    if (stop_q) begin
      sum_l = NEUTRAL_S;
      sum_r = NEUTRAL_S;
      sum_v = NEUTRAL_S;
    end else begin
      sum_l = NEUTRAL_S + SUM_W'(thr_ofs_q) + SUM_W'(str_ofs_q) + SUM_W'(corr_q);
      sum_r = NEUTRAL_S + SUM_W'(thr_ofs_q) - SUM_W'(str_ofs_q) - SUM_W'(corr_q);
      sum_v = NEUTRAL_S + SUM_W'(ver_ofs_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      left_pulse_o     <= clamp_pulse(sum_l, cfg_i.min_pulse, cfg_i.max_pulse);
      right_pulse_o    <= clamp_pulse(sum_r, cfg_i.min_pulse, cfg_i.max_pulse);
      vertical_pulse_o <= clamp_pulse(sum_v, cfg_i.min_pulse, cfg_i.max_pulse);
      hold_active_o    <= hold_q;
      yaw_correction_o <= corr_q;
      heading_error_o  <= err_q;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the thruster mixer with heading hold: directed rows, then random ticks.
`timescale 1ns / 1ps

module testbench;
  import tmhh_pkg::*;

  localparam int unsigned ADC_BITS = ADC_BITS_DEF;
  localparam int ADC_CENTER = 1 << (ADC_BITS - 1);
  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam int PHASES = 8;
  localparam int TICKS_PER_PHASE = 80;
  // Extra settle time at the end, once every expected result has been transferred.
  localparam int RESULT_LATENCY = 70;
  // Watchdog limit in cycles: several times the slowest correct run of near 700 ticks.
  localparam int CYCLE_LIMIT = 400000;

  // One control tick as driven on the input channel.
  typedef struct packed {
    logic [ADC_BITS-1:0] throttle;
    logic [ADC_BITS-1:0] steering;
    logic [ADC_BITS-1:0] vertical;
    logic                toggle;
    logic                stop;
    logic [HEAD_W-1:0]   heading;
    logic [TIME_W-1:0]   now;
  } tick_t;

  // One mixer result as seen on the output channel.
  typedef struct packed {
    logic [PULSE_W-1:0]       left;
    logic [PULSE_W-1:0]       right;
    logic [PULSE_W-1:0]       vert;
    logic                     hold;
    logic signed [YAW_W-1:0]  yaw;
    logic signed [HEAD_W-1:0] err;
  } mix_result_t;

  typedef enum logic {
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  // Directed stimulus row: either a register write or a tick, optionally with a typed result.
  typedef struct {
    row_kind_e        kind;
    cfg_idx_e         reg_idx;
    int               data;
    tick_t            tick;
    bit               typed;
    mix_result_t      want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_e             cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  tmhh_in_if #(.ADC_BITS(ADC_BITS)) in_if ();
  tmhh_out_if                       out_if ();

  thruster_mixer_heading_hold_top #(
    .ADC_BITS(ADC_BITS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the registers and of the button / hold state.
  cfg_t              cfg_m;
  logic              btn_last;
  logic              btn_stable;
  logic [TIME_W-1:0] btn_changed_at;
  logic              hold_on;
  logic [HEAD_W-1:0] hold_target;

  mix_result_t       expected_mix[$];
  stim_row_t         stim_rows[$];
  int                mismatch_count;
  int                cycle_count;
  bit                calm;

  // Random tick generator state: running time and toggle button run length.
  logic [TIME_W-1:0] sim_now;
  logic              tog_level;
  int                tog_run;
  int                ready_hold;

  // 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Map one joystick axis through the dead band to a pulse offset.
  function automatic int stick_offset(logic [ADC_BITS-1:0] raw);
    int c;
    int dz;
    int full;
    int span;
    c    = int'(raw) - ADC_CENTER;
    dz   = int'(cfg_m.deadzone);
    full = int'(cfg_m.max_axis_offset);
    if (c >= -dz && c <= dz) return 0;
    if (c > 0) begin
      span = ADC_CENTER - dz - 2;
      if (span <= 0) return 0;
      return ((c - dz - 1) * full) / span;
    end
    span = ADC_CENTER - dz - 1;
    if (span <= 0) return 0;
    return -(((-c - dz - 1) * full) / span);
  endfunction

  // Clamp with the low bound tested first, so min above max gives min for low values.
  function automatic logic [PULSE_W-1:0] clamp_pulse_us(int v);
    int lo;
    int hi;
    lo = int'(cfg_m.min_pulse);
    hi = int'(cfg_m.max_pulse);
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    return PULSE_W'(v);
  endfunction

  // Advance the button / hold state by one tick and work out the mixer result.
  function automatic mix_result_t predict_mix(tick_t t);
    mix_result_t       r;
    int                thr;
    int                str;
    int                ver;
    int                err;
    int                yaw;
    int                lim;
    logic [TIME_W-1:0] since;
    if (t.toggle != btn_last) btn_changed_at = t.now;
    since = t.now - btn_changed_at;
    if (since > TIME_W'(cfg_m.debounce_ms) && t.toggle != btn_stable) begin
      btn_stable = t.toggle;
      // A settled low level is a press; without a heading sensor it forces hold off.
      if (!btn_stable) begin
        if (!cfg_m.imu_present) begin
          hold_on = 1'b0;
        end else begin
          hold_on = ~hold_on;
          if (hold_on) hold_target = t.heading;
        end
      end
    end
    btn_last = t.toggle;
    if (!hold_on) hold_target = '0;

    thr = stick_offset(t.throttle);
    str = stick_offset(t.steering);
    ver = stick_offset(t.vertical);
    err = 0;
    yaw = 0;
    if (t.stop) begin
      hold_on     = 1'b0;
      hold_target = '0;
      r.left      = clamp_pulse_us(NEUTRAL_PULSE);
      r.right     = clamp_pulse_us(NEUTRAL_PULSE);
      r.vert      = clamp_pulse_us(NEUTRAL_PULSE);
    end else begin
      if (hold_on && cfg_m.imu_present) begin
        err = int'(hold_target) - int'(t.heading);
        while (err > HALF_TURN_Q4) err -= FULL_TURN_Q4;
        while (err < -HALF_TURN_Q4) err += FULL_TURN_Q4;
        // Integer division truncates toward zero, as the gain scaling needs.
        yaw = (err * int'(cfg_m.yaw_gain_q4)) / (1 << GAIN_SHIFT);
        lim = int'(cfg_m.max_yaw_correction);
        if (yaw < -lim) yaw = -lim;
        if (yaw > lim) yaw = lim;
      end
      r.left  = clamp_pulse_us(NEUTRAL_PULSE + thr + str + yaw);
      r.right = clamp_pulse_us(NEUTRAL_PULSE + thr - str - yaw);
      r.vert  = clamp_pulse_us(NEUTRAL_PULSE + ver);
    end
    r.hold = hold_on;
    r.yaw  = YAW_W'(yaw);
    r.err  = HEAD_W'(err);
    return r;
  endfunction

  function automatic void add_tick(int thr, int str, int ver, bit tog, bit stp, int hdg,
                                   logic [TIME_W-1:0] now, bit typed = 1'b0,
                                   int lp = 0, int rp = 0, int vp = 0, bit hold = 1'b0);
    stim_row_t row;
    row.kind          = ROW_TICK;
    row.reg_idx       = CFG_DEADZONE;
    row.data          = 0;
    row.tick.throttle = ADC_BITS'(thr);
    row.tick.steering = ADC_BITS'(str);
    row.tick.vertical = ADC_BITS'(ver);
    row.tick.toggle   = tog;
    row.tick.stop     = stp;
    row.tick.heading  = HEAD_W'(hdg);
    row.tick.now      = now;
    row.typed         = typed;
    row.want.left     = PULSE_W'(lp);
    row.want.right    = PULSE_W'(rp);
    row.want.vert     = PULSE_W'(vp);
    row.want.hold     = hold;
    row.want.yaw      = '0;
    row.want.err      = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, int value);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.data    = value;
    row.tick    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    stim_rows.push_back(row);
  endfunction

  // Axis sample: extremes, values around the dead band edges, or anything.
  function automatic logic [ADC_BITS-1:0] rand_axis();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1) ? ADC_MAX : 0;
      1: begin
        v = ADC_CENTER + int'(cfg_m.deadzone) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = 2 * ADC_CENTER - v;
      end
      default: v = int'($urandom_range(0, ADC_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return ADC_BITS'(v);
  endfunction

  // Ticks follow a running clock with held button levels, plus jumps and bounces.
  function automatic tick_t make_random_tick();
    tick_t t;
    if ($urandom_range(0, 39) == 0) sim_now = $urandom;
    else sim_now += $urandom_range(0, 12);
    if (tog_run == 0) begin
      tog_level = ~tog_level;
      tog_run   = $urandom_range(1, 12);
    end
    tog_run--;
    t.throttle = rand_axis();
    t.steering = rand_axis();
    t.vertical = rand_axis();
    t.toggle   = ($urandom_range(0, 19) == 0) ? ~tog_level : tog_level;
    t.stop     = ($urandom_range(0, 24) == 0);
    t.heading  = ($urandom_range(0, 9) == 0) ? HEAD_W'($urandom_range(0, (1 << HEAD_W) - 1))
                                             : HEAD_W'($urandom_range(0, FULL_TURN_Q4 - 1));
    t.now      = sim_now;
    return t;
  endfunction

  // Drive one tick, optionally after a short gap, and log its expected result on transfer.
  task automatic send_tick(tick_t t, bit typed, mix_result_t want);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.throttle_raw <= t.throttle;
    in_if.steering_raw <= t.steering;
    in_if.vertical_raw <= t.vertical;
    in_if.toggle_level <= t.toggle;
    in_if.stop_pressed <= t.stop;
    in_if.heading      <= t.heading;
    in_if.now_ms       <= t.now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (typed) begin
      void'(predict_mix(t));
      expected_mix.push_back(want);
    end else begin
      expected_mix.push_back(predict_mix(t));
    end
  endtask

  // Drop valid and hold until every expected result has been transferred.
  task automatic wait_drained(int settle);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_W'(value);
    case (idx)
      CFG_DEADZONE:    cfg_m.deadzone           = BYTE_W'(value);
      CFG_AXIS_OFFSET: cfg_m.max_axis_offset    = OFF_W'(value);
      CFG_YAW_LIMIT:   cfg_m.max_yaw_correction = BYTE_W'(value);
      CFG_YAW_GAIN:    cfg_m.yaw_gain_q4        = BYTE_W'(value);
      CFG_DEBOUNCE:    cfg_m.debounce_ms        = DEB_W'(value);
      CFG_IMU_PRESENT: cfg_m.imu_present        = value[0];
      CFG_MIN_PULSE:   cfg_m.min_pulse          = PULSE_W'(value);
      CFG_MAX_PULSE:   cfg_m.max_pulse          = PULSE_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Register setting of one random phase: two extreme corners first, then random ones.
  task automatic set_phase_regs(int p);
    int dz;
    int ofs;
    int lim;
    int gain;
    int deb;
    int imu;
    int lo;
    int hi;
    int swap;
    case (p)
      0: begin
        dz = 255; ofs = 500; lim = 255; gain = 255; deb = 0; imu = 1; lo = 500; hi = 2500;
      end
      1: begin
        dz = 0; ofs = 0; lim = 0; gain = 0; deb = 65535; imu = 0; lo = 2500; hi = 500;
      end
      default: begin
        dz   = $urandom_range(0, 255);
        ofs  = $urandom_range(0, 500);
        lim  = $urandom_range(0, 255);
        gain = $urandom_range(0, 255);
        deb  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
        imu  = ($urandom_range(0, 3) != 0);
        lo   = $urandom_range(500, 2500);
        hi   = $urandom_range(500, 2500);
        // Keep most phases well ordered so the mix is visible in the pulses.
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
      end
    endcase
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_AXIS_OFFSET, ofs);
    write_reg(CFG_YAW_LIMIT, lim);
    write_reg(CFG_YAW_GAIN, gain);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_IMU_PRESENT, imu);
    write_reg(CFG_MIN_PULSE, lo);
    write_reg(CFG_MAX_PULSE, hi);
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: drops ready in random stall bursts, none in the calm part.
  initial begin
    out_if.ready = 1'b0;
    ready_hold   = 0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_if.ready <= 1'b0;
        ready_hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        ready_hold = $urandom_range(0, 4);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare every result transfer against the oldest pending expectation.
  always @(posedge clk) begin : check_results
    mix_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_mix.size() == 0) begin
        $display("%0t: result transfer with nothing pending, left %0d right %0d", $time,
                 out_if.left_pulse, out_if.right_pulse);
        mismatch_count++;
      end else begin
        want = expected_mix.pop_front();
        check_field("left_pulse", want.left, out_if.left_pulse);
        check_field("right_pulse", want.right, out_if.right_pulse);
        check_field("vertical_pulse", want.vert, out_if.vertical_pulse);
        check_field("hold_active", want.hold, out_if.hold_active);
        check_field("yaw_correction", want.yaw, out_if.yaw_correction);
        check_field("heading_error", want.err, out_if.heading_error);
      end
    end
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, expected_mix.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value from time zero and hold reset.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_DEADZONE;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.throttle_raw = '0;
    in_if.steering_raw = '0;
    in_if.vertical_raw = '0;
    in_if.toggle_level = 1'b1;
    in_if.stop_pressed = 1'b0;
    in_if.heading      = '0;
    in_if.now_ms       = '0;
    calm               = 1'b0;
    mismatch_count     = 0;
    cycle_count        = 0;

    // Shadow state after reset: defaults, button released, hold off.
    cfg_m.deadzone           = DEADZONE_RST;
    cfg_m.max_axis_offset    = AXIS_OFS_RST;
    cfg_m.max_yaw_correction = YAW_LIM_RST;
    cfg_m.yaw_gain_q4        = YAW_GAIN_RST;
    cfg_m.debounce_ms        = DEBOUNCE_RST;
    cfg_m.imu_present        = 1'b0;
    cfg_m.min_pulse          = MIN_PULSE_RST;
    cfg_m.max_pulse          = MAX_PULSE_RST;
    btn_last                 = 1'b1;
    btn_stable               = 1'b1;
    btn_changed_at           = '0;
    hold_on                  = 1'b0;
    hold_target              = '0;
    sim_now                  = '0;
    tog_level                = 1'b1;
    tog_run                  = 0;

    // Directed rows under reset defaults: center, full deflection, dead band edges.
    add_tick(512, 512, 512, 1, 0, 0, 0, 1, 1500, 1500, 1500, 0);
    add_tick(1023, 512, 512, 1, 0, 0, 5, 1, 1600, 1600, 1500, 0);
    add_tick(0, 512, 512, 1, 0, 0, 10, 1, 1400, 1400, 1500, 0);
    add_tick(512, 1023, 1023, 1, 0, 0, 15, 1, 1600, 1400, 1600, 0);
    add_tick(512, 0, 0, 1, 0, 0, 20, 1, 1400, 1600, 1400, 0);
    add_tick(572, 452, 573, 1, 0, 0, 25, 1, 1500, 1500, 1500, 0);
    // Settled press without a heading sensor: hold is refused.
    add_tick(512, 512, 512, 0, 0, 0, 30);
    add_tick(512, 512, 512, 0, 0, 0, 90, 1, 1500, 1500, 1500, 0);
    add_tick(512, 512, 512, 1, 0, 0, 100);
    add_tick(512, 512, 512, 1, 0, 0, 200);
    // With the sensor present: press captures the heading, then sweep the error wrap.
    add_cfg(CFG_IMU_PRESENT, 1);
    add_cfg(CFG_DEBOUNCE, 5);
    add_tick(512, 512, 512, 0, 0, 1000, 300);
    add_tick(512, 512, 512, 0, 0, 1000, 306);
    add_tick(700, 300, 512, 0, 0, 1100, 307);
    add_tick(512, 512, 512, 0, 0, 0, 308);
    add_tick(512, 512, 512, 0, 0, 8191, 309);
    add_tick(512, 512, 512, 0, 0, 3880, 310);
    add_tick(512, 512, 512, 0, 0, 4000, 311);
    // Sensor lost while holding: hold stays on, no correction.
    add_cfg(CFG_IMU_PRESENT, 0);
    add_tick(512, 512, 512, 0, 0, 500, 312);
    add_cfg(CFG_IMU_PRESENT, 1);
    // Stop forces neutral and ends hold.
    add_tick(1023, 0, 1023, 0, 1, 500, 313, 1, 1500, 1500, 1500, 0);
    // Min above max: neutral falls below min and takes it.
    add_cfg(CFG_MIN_PULSE, 1600);
    add_cfg(CFG_MAX_PULSE, 1400);
    add_tick(512, 512, 512, 0, 0, 0, 314, 1, 1600, 1600, 1600, 0);
    // Widest range and gain: full deflection, then a hold at the top of the heading range.
    add_cfg(CFG_MIN_PULSE, 500);
    add_cfg(CFG_MAX_PULSE, 2500);
    add_cfg(CFG_AXIS_OFFSET, 500);
    add_cfg(CFG_DEADZONE, 0);
    add_cfg(CFG_YAW_LIMIT, 255);
    add_cfg(CFG_YAW_GAIN, 255);
    add_tick(1023, 1023, 1023, 1, 0, 0, 320);
    add_tick(0, 0, 0, 1, 0, 0, 330);
    add_tick(512, 512, 512, 0, 0, 5759, 340);
    add_tick(1023, 512, 0, 0, 0, 5759, 350);
    add_tick(0, 1023, 512, 0, 0, 2000, 351);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows; register writes only once the block is drained.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        wait_drained(2);
        write_reg(stim_rows[i].reg_idx, stim_rows[i].data);
      end else begin
        send_tick(stim_rows[i].tick, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases, each under its own register setting; the last one runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained(2);
      calm = (p == PHASES - 1);
      // Cross the millisecond wrap in one phase.
      if (p == 3) sim_now = 32'hFFFF_FFA0;
      set_phase_regs(p);
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        // Hold off once mid-phase until the output side has caught up.
        if (p == 4 && k == TICKS_PER_PHASE / 2) wait_drained(0);
        send_tick(make_random_tick(), 1'b0, '0);
      end
    end

    wait_drained(RESULT_LATENCY);
    if (mismatch_count == 0 && expected_mix.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
